/* src/btc_pkg.sv */
// Package: sizes, payload types and helpers for the boxcar threshold block
`default_nettype none
package btc_pkg;
  localparam int LANES    = 8;
  localparam int PIXELS   = 256;
  localparam int WIDTHS   = 16;
  localparam int GROUPS   = PIXELS / LANES;
  localparam int DEPTH    = WIDTHS - 1;
  localparam int SUM_W    = 24;
  localparam int SAMPLE_W = 16;
  localparam int GROUP_W  = 5;
  localparam int LANE_W   = 3;
  localparam int CAND_W   = 23;
  localparam int ADDR_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sum_t [DEPTH-1:0]           hist_t;

  typedef struct packed {
    sample_t [7:0]      sample;
    logic [GROUP_W-1:0] pixel_group;
    logic               clear_history;
  } in_item_t;

  typedef struct packed {
    logic [CAND_W-1:0]  candidate_value;
    logic [LANE_W-1:0]  lane_index;
    logic [GROUP_W-1:0] group_index;
    logic               last_of_item;
  } out_item_t;

  // Per-lane finding handed to the merge stage
  typedef struct packed {
    logic              hit;
    logic [CAND_W-1:0] value;
  } lane_res_t;
endpackage
`default_nettype wire

/* src/btc_if.sv */
// Valid/ready channel interfaces for input and result transactions
`default_nettype none
interface btc_in_if import btc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface btc_out_if import btc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface btc_cfg_if ();
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/btc_lane.sv */
// One lane: per-pixel history memory, boxcar sums, best and threshold test
`default_nettype none
module btc_lane import btc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,       // transaction accepted this cycle
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic              use_lane,   // pixel in range
  input  wire logic              clear,
  input  wire sample_t           sample,
  input  wire logic              adv,        // stage 1 -> stage 2 move
  input  wire sum_t              threshold,
  output lane_res_t              res
);
  hist_t mem [GROUPS];
  hist_t rd_r;
  logic  s1_v_r, s1_use_r, s1_clr_r;
  logic [ADDR_W-1:0] s1_addr_r;
  sample_t s1_x_r;
  // bypass for back-to-back hits on the same group
  hist_t byp_r;

  hist_t old_h, new_h;
  sum_t  best;
  sum_t  mx [1:2*WIDTHS-1];
  lane_res_t res_nxt;

  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r      <= mem[addr];
      s1_addr_r <= addr;
      s1_x_r    <= sample;
      s1_use_r  <= use_lane;
      s1_clr_r  <= clear;
    end
    if (adv && s1_v_r && s1_use_r) begin
      mem[s1_addr_r] <= new_h;
      byp_r          <= new_h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      if (fire) s1_v_r <= 1'b1;
      else if (adv) s1_v_r <= 1'b0;
    end
  end

  // History reset to zero is not done per entry: a valid bit per group
  logic [GROUPS-1:0] written_r;
  logic wr_at_read_r;
  always_ff @(posedge clk) begin
    if (!rst_n) written_r <= '0;
    else if (adv && s1_v_r && s1_use_r) written_r[s1_addr_r] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (fire) wr_at_read_r <= written_r[addr] &&
      !(adv && s1_v_r && s1_use_r && s1_addr_r == addr);
  end

  // freshness: bypass if a write hit this group at the same edge as the read
  logic byp_hit_r;
  always_ff @(posedge clk) begin
    if (fire) byp_hit_r <= adv && s1_v_r && s1_use_r && s1_addr_r == addr;
  end

  always_comb begin
    if (s1_clr_r) old_h = '0;
    else if (byp_hit_r) old_h = byp_r;
    else if (wr_at_read_r) old_h = rd_r;
    else old_h = '0;
    // leaves: the sample alone, then each stored sum plus the sample
    mx[WIDTHS] = SUM_W'(s1_x_r);
    for (int k = 0; k < DEPTH; k++) mx[WIDTHS+1+k] = old_h[k] + SUM_W'(s1_x_r);
    // max tree keeps the compare depth logarithmic
    for (int i = WIDTHS-1; i >= 1; i--)
      mx[i] = (mx[2*i] > mx[2*i+1]) ? mx[2*i] : mx[2*i+1];
    best = (mx[1] > 0) ? mx[1] : '0;
    new_h[0] = SUM_W'(s1_x_r);
    for (int k = 1; k < DEPTH; k++) new_h[k] = old_h[k-1] + SUM_W'(s1_x_r);
    res_nxt.hit   = s1_use_r && (best > 0) && (best > threshold);
    res_nxt.value = best[CAND_W-1:0];
  end

  assign res = res_nxt;
endmodule
`default_nettype wire

/* src/btc_merge.sv */
// Merge stage: walks the lane hits of one transaction and emits candidates
`default_nettype none
module btc_merge import btc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,      // new lane results arrive
  input  wire lane_res_t [LANES-1:0] res,
  input  wire logic [GROUP_W-1:0] group,
  output logic                    busy,      // holds lane results not yet drained
  output logic                    will_free, // drains completely this cycle
  btc_out_if.source               out
);
  logic [LANES-1:0] pend_r, pend_nxt;
  logic [GROUP_W-1:0] grp_r;
  logic [CAND_W-1:0] val_r [LANES];
  logic [LANE_W-1:0] sel;
  logic [LANES-1:0] rest;

  always_comb begin
    sel = '0;
    for (int i = LANES-1; i >= 0; i--) if (pend_r[i]) sel = LANE_W'(i);
    rest = pend_r;
    rest[sel] = 1'b0;
    pend_nxt = pend_r;
    if (out.valid && out.ready) pend_nxt = rest;
  end

  assign busy      = |pend_r;
  assign will_free = (pend_nxt == '0);
  assign out.valid = |pend_r;
  assign out.data.candidate_value = val_r[sel];
  assign out.data.lane_index      = sel;
  assign out.data.group_index     = grp_r;
  assign out.data.last_of_item    = (rest == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else if (load) begin
      for (int i = 0; i < LANES; i++) pend_r[i] <= res[i].hit;
    end else pend_r <= pend_nxt;
  end
  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= group;
      for (int i = 0; i < LANES; i++) val_r[i] <= res[i].value;
    end
  end

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && out.data.last_of_item |-> $onehot(pend_r)) else $error("last flag");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && out.ready && !load |=> $countones(pend_r) == $countones($past(pend_r)) - 1)
    else $error("drain");
  a_noload: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy || will_free) else $error("overwrite");
endmodule
`default_nettype wire

/* src/boxcar_threshold_candidates_top.sv */
// Top level: lane array, merge stage and threshold register
// Path: stage-1 registers (memory read), combinational sum and test, merge registers.
// Throughput: one input per cycle while each yields at most one candidate and out
// is ready; an input with n hits holds the merge stage until its n candidates drain, one per cycle.
// Reset: synchronous active low; clears control and the per-group history
// valid bits, so all stored sums read as zero; threshold resets to 0.
`default_nettype none
module boxcar_threshold_candidates_top import btc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  btc_in_if.sink    in,
  btc_out_if.source out,
  btc_cfg_if.sink   cfg
);
  sum_t thr_r;
  logic [GROUP_W-1:0] s1_grp_r;
  logic s1_v_r;
  logic busy, will_free, adv, fire;
  lane_res_t [LANES-1:0] res;

  // stage 1 moves into the merge stage when the merge can take it
  assign adv   = !busy || will_free;
  assign in.ready = adv || !s1_v_r;
  assign fire  = in.valid && in.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= '0;
    else if (cfg.valid) thr_r <= cfg.data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      if (fire) s1_v_r <= 1'b1;
      else if (adv) s1_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (fire) s1_grp_r <= in.data.pixel_group;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [GROUP_W+LANE_W:0] pix;
    assign pix = {1'b0, in.data.pixel_group, LANE_W'(0)} + (GROUP_W+LANE_W+1)'(l);
    btc_lane u_lane (
      .clk, .rst_n, .fire,
      .addr      (in.data.pixel_group[ADDR_W-1:0]),
      .use_lane  (pix < (GROUP_W+LANE_W+1)'(PIXELS)),
      .clear     (in.data.clear_history),
      .sample    (in.data.sample[l]),
      .adv,
      .threshold (thr_r),
      .res       (res[l])
    );
  end

  btc_merge u_merge (
    .clk, .rst_n,
    .load (adv && s1_v_r),
    .res, .group (s1_grp_r),
    .busy, .will_free, .out
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r) else $error("stage lost");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in.ready) else $error("ready");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.valid |=> thr_r == $past(cfg.data)) else $error("cfg");
endmodule
`default_nettype wire

/* tb/sv/btc_tb_scoreboard.sv */
// Candidate predictor and scoreboard for the boxcar threshold testbench
`timescale 1ns / 100ps
package btc_tb_pkg;
  import btc_pkg::*;

  class btc_candidate_sb;
    int               sums[PIXELS][DEPTH];
    int               thresh;
    out_item_t        pending[$];
    int               errors;

    function void reset_state();
      foreach (sums[p, k]) sums[p][k] = 0;
      thresh = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void set_threshold(logic [SUM_W-1:0] v);
      thresh = $signed(v);
    endfunction

    // accepted input transaction: update sums, queue candidates
    function void note_burst(in_item_t it);
      out_item_t found[$];
      out_item_t c;
      int pix, x, best, s;
      for (int ln = 0; ln < LANES; ln++) begin
        pix = int'(it.pixel_group) * LANES + ln;
        if (pix >= PIXELS) continue;
        if (it.clear_history)
          for (int k = 0; k < DEPTH; k++) sums[pix][k] = 0;
        x = int'(it.sample[ln]);
        best = (x > 0) ? x : 0;
        s = sums[pix][DEPTH-1] + x;
        if (s > best) best = s;
        for (int k = DEPTH - 1; k > 0; k--) begin
          s = sums[pix][k-1] + x;
          if (s > best) best = s;
          sums[pix][k] = s;
        end
        sums[pix][0] = x;
        if (best > 0 && best > thresh) begin
          c.candidate_value = best[CAND_W-1:0];
          c.lane_index      = ln[LANE_W-1:0];
          c.group_index     = it.pixel_group;
          c.last_of_item    = 1'b0;
          found.push_back(c);
        end
      end
      if (found.size() > 0) found[found.size()-1].last_of_item = 1'b1;
      foreach (found[i]) pending.push_back(found[i]);
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check_candidate(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected candidate %p", got));
        return;
      end
      w = pending.pop_front();
      if (got.candidate_value !== w.candidate_value)
        report($sformatf("value got %0d want %0d", got.candidate_value, w.candidate_value));
      if (got.lane_index !== w.lane_index)
        report($sformatf("lane got %0d want %0d", got.lane_index, w.lane_index));
      if (got.group_index !== w.group_index)
        report($sformatf("group got %0d want %0d", got.group_index, w.group_index));
      if (got.last_of_item !== w.last_of_item)
        report($sformatf("last got %0b want %0b", got.last_of_item, w.last_of_item));
    endfunction
  endclass
endpackage

/* tb/sv/boxcar_threshold_candidates_top_tb.sv */
// Testbench top: drives bursts and threshold writes, checks candidates
`timescale 1ns / 100ps
module boxcar_threshold_candidates_top_tb;
  import btc_pkg::*;
  import btc_tb_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst_n;
  btc_in_if  in_ch ();
  btc_out_if out_ch ();
  btc_cfg_if cfg_ch ();

  btc_candidate_sb sb;
  int  stall_mode;
  int  idle_cycles;
  bit  timed_out;

  boxcar_threshold_candidates_top dut (
    .clk(clk), .rst_n(rst_n), .in(in_ch.sink), .out(out_ch.source), .cfg(cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: ready pattern, check on accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_candidate(out_ch.data);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_threshold(logic [SUM_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_threshold(v);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_burst(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_burst(it);
  endtask

  task automatic pause_input();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // wait for all candidates, then allow the pipeline to settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(int kind);
    case (kind)
      0: return sample_t'($urandom());
      1: return sample_t'($urandom_range(0, 4000)) - 16'sd1000;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_phase(int n, int kind);
    in_item_t it;
    int burst;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      for (int l = 0; l < 8; l++) it.sample[l] = rand_sample(kind);
      it.pixel_group   = ($urandom_range(0, 3) == 0) ? GROUP_W'($urandom())
                                                     : GROUP_W'($urandom_range(0, 3));
      it.clear_history = ($urandom_range(0, 15) == 0);
      send_burst(it);
      if (--burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) pause_input();
      end
    end
  endtask

  initial begin
    in_item_t it;
    sb = new();
    sb.reset_state();
    stall_mode   = 0;
    idle_cycles  = 0;
    timed_out    = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, clear, zero best with negative threshold
    for (int l = 0; l < 8; l++) it.sample[l] = 16'sh7fff;
    it.pixel_group = 0; it.clear_history = 1'b0;
    for (int i = 0; i < 17; i++) send_burst(it);
    for (int l = 0; l < 8; l++) it.sample[l] = 16'sh8000;
    it.pixel_group = 5'd31;
    send_burst(it);
    it.clear_history = 1'b1; it.pixel_group = 0;
    send_burst(it);
    for (int l = 0; l < 8; l++) it.sample[l] = (l[0]) ? 16'sd0 : -16'sd5;
    it.clear_history = 1'b0; it.pixel_group = 5'd7;
    send_burst(it);
    drain();
    write_threshold(24'h800000);
    send_burst(it);
    it.clear_history = 1'b1; it.pixel_group = 5'd31;
    for (int l = 0; l < 8; l++) it.sample[l] = 16'sh7fff;
    send_burst(it);
    drain();
    write_threshold(24'h7fffff);
    random_phase(20, 0);
    drain();

    write_threshold(24'd0);
    stall_mode = 0;
    random_phase(70, 0);
    drain();
    write_threshold(24'd30000);
    stall_mode = 1;
    random_phase(70, 2);
    drain();
    write_threshold(-24'sd500);
    stall_mode = 2;
    random_phase(60, 1);
    drain();
    write_threshold(24'd1000);
    stall_mode = 1;
    random_phase(50, 1);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
